>>> src/bdes_pkg.sv
// Package: shared constants and the DCT cosine table for the energy split unit.
`default_nettype none
package bdes_pkg;
  localparam int MaxBlocks = 1024;
  localparam int CntW = 11;
  localparam logic [47:0] TotalMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [33:0] EnergyMax = 34'h3_FFFF_FFFF;

  function automatic logic signed [15:0] cos_q14(input logic [2:0] k, input logic [2:0] n);
    logic [4:0] j;
    logic [3:0] q;
    logic signed [15:0] m;
    logic neg;
    j = 5'(({2'b0, n, 1'b1} * {2'b0, k}));
    neg = 1'b0;
    q = 4'd0;
    if (j <= 5'd8) begin
      q = j[3:0];
    end else if (j <= 5'd16) begin
      q = 4'(5'd16 - j); neg = 1'b1;
    end else if (j <= 5'd24) begin
      q = 4'(j - 5'd16); neg = 1'b1;
    end else begin
      q = 4'(6'd32 - {1'b0, j});
    end
    unique case (q)
      4'd0: m = 16'sd16384;
      4'd1: m = 16'sd16069;
      4'd2: m = 16'sd15137;
      4'd3: m = 16'sd13623;
      4'd4: m = 16'sd11585;
      4'd5: m = 16'sd9102;
      4'd6: m = 16'sd6270;
      4'd7: m = 16'sd3196;
      default: m = 16'sd0;
    endcase
    return neg ? -m : m;
  endfunction
endpackage
`default_nettype wire

>>> src/bdes_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bdes_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/bdes_div.sv
// Restoring divider: 48-bit total by 11-bit block count, one quotient bit per cycle.
`default_nettype none
module bdes_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [10:0] divisor,
  output logic             done,
  output logic [47:0]      quotient
);
  logic [5:0]  cnt_r;
  logic        run_r;
  logic [47:0] q_r;
  logic [11:0] rem_r;
  logic [10:0] d_r;
  logic [11:0] trial;
  always_comb trial = {rem_r[10:0], q_r[47]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done <= 1'b0;
      cnt_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        q_r <= dividend;
        rem_r <= '0;
        d_r <= divisor;
      end else if (run_r) begin
        if (trial >= {1'b0, d_r}) begin
          rem_r <= trial - {1'b0, d_r};
          q_r <= {q_r[46:0], 1'b1};
        end else begin
          rem_r <= trial;
          q_r <= {q_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          run_r <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quotient = q_r;
endmodule
`default_nettype wire

>>> src/block_dct_energy_split_unit.sv
// Top level: 8x8 DCT-II energy split with a single shared multiply-accumulate unit.
`default_nettype none
// Pixels are taken one per cycle while busy is low, so pixels 1..63 of a block
// can come back to back. The 64th pixel starts the transform on one shared 32x24
// multiplier. Each of the 64 row-pass coefficients takes a read, 8 MAC steps and
// a write. Each of the 64 column-pass coefficients takes a read, 8 MAC steps, a
// round and a square. Saturation, the totals and the result follow, and busy
// stays high until the result. A last block adds two runs of the bit-serial
// mean divider, one for the low and one for the high total.
// The result is on out_valid for one cycle, in the cycle where busy falls. The
// receiver cannot stall.
module block_dct_energy_split_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic        in_last_block,
  output logic             out_valid,
  output logic [33:0]      out_block_low,
  output logic [33:0]      out_block_high,
  output logic [33:0]      out_mean_low,
  output logic [33:0]      out_mean_high,
  output logic             out_final_res
);
  typedef enum logic [3:0] {
    S_IDLE, S_ROWRD, S_ROWMAC, S_ROWWR, S_COLRD, S_COLMAC, S_COLRND, S_SQ, S_ACC,
    S_TOT, S_DIVL, S_DIVH, S_OUT
  } state_t;

  state_t      state_r;
  logic        gray_r;
  logic [5:0]  pix_r;
  logic        last_r;
  logic [2:0]  a_r, b_r, n_r, tap_r;   // a: row/v, b: k/u, n: read tap, tap: tap of read data
  logic signed [63:0] acc_r;
  logic signed [23:0] coef_r;
  logic [51:0] lo_r, hi_r;
  logic [47:0] lot_r, hit_r;
  logic [bdes_pkg::CntW-1:0] cnt_r;
  logic [33:0] elo_r, ehi_r, mlo_r;
  logic        dstart_r;
  logic [47:0] ddiv_r;
  logic        ddone;
  logic [47:0] dq;
  logic [33:0] obl_r, obh_r, oml_r, omh_r;
  logic        ov_r, of_r;

  // sample store
  logic        s_we;
  logic [23:0] s_wd, s_rd;
  logic [5:0]  s_ra;
  logic        t_we;
  logic [5:0]  t_wa, t_ra;
  logic [31:0] t_wd, t_rd;

  // shared multiplier operands
  logic signed [15:0] cf;
  logic signed [31:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [55:0] prod;
  logic signed [63:0] mac;
  logic signed [63:0] rnd;
  logic [63:0] mag;
  logic [4:0]  sh;

  logic [47:0] nl, nh;
  logic        cnt_ok;

  always_comb begin
    s_we = start && !busy;
    s_wd = gray_r ? {in_red, 16'd0}
                  : 24'd19595 * {16'd0, in_red} + 24'd38470 * {16'd0, in_green}
                    + 24'd7471 * {16'd0, in_blue};
  end
  bdes_ram #(.Width(24), .Depth(64)) u_samp (
    .clk, .we(s_we), .waddr(pix_r), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  bdes_ram #(.Width(32), .Depth(64)) u_rowt (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  bdes_div u_div (.clk, .rst_n, .start(dstart_r), .dividend(ddiv_r), .divisor(cnt_r),
    .done(ddone), .quotient(dq));

  always_comb begin
    cf = bdes_pkg::cos_q14(b_r, tap_r);
    if (state_r == S_SQ) begin
      mul_a = 32'(coef_r);
      mul_b = coef_r;
    end else begin
      mul_a = (state_r == S_COLMAC) ? $signed(t_rd) : $signed({8'd0, s_rd});
      mul_b = 24'(cf);
    end
    prod = 56'(mul_a) * 56'(mul_b);
    mac = acc_r + 64'(prod);
    sh = (state_r == S_ROWWR) ? 5'd14 : 5'd22;
    mag = acc_r[63] ? 64'(-acc_r) : 64'(acc_r);
    mag = (mag + (64'd1 << (sh - 5'd1))) >> sh;
    rnd = acc_r[63] ? -$signed(mag) : $signed(mag);
    // read addresses: row stage walks samples of row a, column stage row n of column a
    s_ra = {a_r, n_r};
    t_ra = {n_r, a_r};
    t_we = (state_r == S_ROWWR);
    t_wa = {a_r, b_r};
    t_wd = rnd[31:0];
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    nl = ({1'b0, lot_r} + {15'd0, elo_r} > {1'b0, bdes_pkg::TotalMax})
         ? bdes_pkg::TotalMax : lot_r + {14'd0, elo_r};
    nh = ({1'b0, hit_r} + {15'd0, ehi_r} > {1'b0, bdes_pkg::TotalMax})
         ? bdes_pkg::TotalMax : hit_r + {14'd0, ehi_r};
    cnt_ok = (cnt_r < bdes_pkg::CntW'(bdes_pkg::MaxBlocks)) || last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gray_r <= 1'b0;
      pix_r <= '0;
      lot_r <= '0;
      hit_r <= '0;
      cnt_r <= '0;
      ov_r <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      dstart_r <= 1'b0;
      if (cfg_we) gray_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (s_we) begin
            pix_r <= pix_r + 6'd1;
            last_r <= in_last_block;
            if (pix_r == 6'd63) begin
              state_r <= S_ROWRD;
              a_r <= '0; b_r <= '0; n_r <= '0;
              lo_r <= '0; hi_r <= '0;
            end
          end
        end
        S_ROWRD, S_COLRD: begin
          acc_r <= '0;
          n_r <= 3'd1;
          tap_r <= '0;
          state_r <= (state_r == S_ROWRD) ? S_ROWMAC : S_COLMAC;
        end
        // read data of tap tap_r arrives in the cycle after its address
        S_ROWMAC, S_COLMAC: begin
          acc_r <= mac;
          n_r <= n_r + 3'd1;
          tap_r <= tap_r + 3'd1;
          if (tap_r == 3'd7) state_r <= (state_r == S_ROWMAC) ? S_ROWWR : S_COLRND;
        end
        S_ROWWR: begin
          n_r <= '0;
          b_r <= b_r + 3'd1;
          if (b_r == 3'd7) a_r <= a_r + 3'd1;
          state_r <= (b_r == 3'd7 && a_r == 3'd7) ? S_COLRD : S_ROWRD;
        end
        S_COLRND: begin
          coef_r <= rnd[23:0];
          n_r <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          if (!(a_r == 3'd0 && b_r == 3'd0)) begin
            if (!a_r[2] && !b_r[2]) lo_r <= lo_r + prod[51:0];
            else hi_r <= hi_r + prod[51:0];
          end
          b_r <= b_r + 3'd1;
          if (b_r == 3'd7) a_r <= a_r + 3'd1;
          state_r <= (b_r == 3'd7 && a_r == 3'd7) ? S_ACC : S_COLRD;
        end
        S_ACC: begin
          elo_r <= (lo_r[51:50] != 2'd0) ? bdes_pkg::EnergyMax : lo_r[49:16];
          ehi_r <= (hi_r[51:50] != 2'd0) ? bdes_pkg::EnergyMax : hi_r[49:16];
          state_r <= S_TOT;
        end
        S_TOT: begin
          if (cnt_ok) begin
            lot_r <= nl; hit_r <= nh; cnt_r <= cnt_r + bdes_pkg::CntW'(1);
          end
          if (last_r) begin
            ddiv_r <= cnt_ok ? nl : lot_r;
            dstart_r <= 1'b1;
            state_r <= S_DIVL;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIVL: begin
          if (ddone) begin
            mlo_r <= dq[33:0];
            ddiv_r <= hit_r;
            dstart_r <= 1'b1;
            state_r <= S_DIVH;
          end
        end
        S_DIVH: begin
          if (ddone) begin
            oml_r <= mlo_r; omh_r <= dq[33:0];
            lot_r <= '0; hit_r <= '0; cnt_r <= '0;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          obl_r <= elo_r; obh_r <= ehi_r; of_r <= last_r;
          if (!last_r) begin oml_r <= '0; omh_r <= '0; end
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid = ov_r;
    out_block_low = obl_r;
    out_block_high = obh_r;
    out_mean_low = oml_r;
    out_mean_high = omh_r;
    out_final_res = of_r;
  end

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && $past(busy)) |-> $stable(pix_r)) else $error("pixel taken while busy");
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_res) |-> (cnt_r == '0)) else $error("count not cleared");
endmodule
`default_nettype wire
